### rtl/sbc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package sbc_pkg;

	localparam int WORD_W  = 32;
	localparam int POS_W   = 4;
	localparam int DIG_N   = 8;
	localparam int IDX_W   = 3;
	localparam int ROUNDS  = 64;
	localparam int RND_W   = 6;
	localparam int SCHED_N = 16;
	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = 2;
	localparam int Q_CNT_W = 3;

	localparam logic [POS_W-1:0] POS_LAST = 4'hF;
	localparam logic [IDX_W-1:0] IDX_LAST = 3'd7;
	localparam logic [RND_W-1:0] RND_LAST = 6'd63;

	localparam logic [WORD_W-1:0] IV_TABLE [DIG_N] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [WORD_W-1:0] K_TABLE [ROUNDS] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	// one classified word on its way from front to back
	typedef struct packed {
		logic [WORD_W-1:0] word;
		logic              reload;   // load IV before this word
		logic              blk_end;  // sixteenth word of the block
	} item_t;

	// queue status seen by the front and the core
	typedef struct packed {
		logic full;
		logic valid;
	} q_stat_t;

	function automatic logic [WORD_W-1:0] big_sig0(input logic [WORD_W-1:0] x);
		big_sig0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic logic [WORD_W-1:0] big_sig1(input logic [WORD_W-1:0] x);
		big_sig1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	function automatic logic [WORD_W-1:0] sml_sig0(input logic [WORD_W-1:0] x);
		sml_sig0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
	endfunction

	function automatic logic [WORD_W-1:0] sml_sig1(input logic [WORD_W-1:0] x);
		sml_sig1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
	endfunction

endpackage
`default_nettype wire

### rtl/sbc_front.sv
`timescale 1ns / 1ps
`default_nettype none
module sbc_front (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    s_tvalid,
	output logic                         s_tready,
	input  wire logic [31:0]             s_tdata,   // [31:0] message_word
	input  wire logic [0:0]              s_tuser,   // [0] new_message
	input  wire sbc_pkg::q_stat_t        q_stat,
	output logic                         push,
	output sbc_pkg::item_t               push_item
);
	import sbc_pkg::*;

	logic [POS_W-1:0] pos_q;

	assign s_tready = !q_stat.full;
	assign push     = s_tvalid && s_tready;

	assign push_item.word    = s_tdata;
	assign push_item.reload  = s_tuser[0];
	assign push_item.blk_end = (pos_q == POS_LAST);

	// word position in block; wraps after the sixteenth
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (push) begin
			pos_q <= pos_q + 1'b1;
		end
	end

endmodule
`default_nettype wire

### rtl/sbc_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module sbc_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire sbc_pkg::item_t   push_item,
	input  wire logic             pop,
	output sbc_pkg::item_t        head_item,
	output sbc_pkg::q_stat_t      q_stat
);
	import sbc_pkg::*;

	item_t              ent_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_q;
	logic [Q_PTR_W-1:0] rd_q;
	logic [Q_CNT_W-1:0] cnt_q;

	assign q_stat.full  = (cnt_q == Q_CNT_W'(Q_DEPTH));
	assign q_stat.valid = (cnt_q != '0);
	assign head_item    = ent_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule
`default_nettype wire

### rtl/sbc_core.sv
`timescale 1ns / 1ps
`default_nettype none
module sbc_core (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire sbc_pkg::q_stat_t q_stat,
	input  wire sbc_pkg::item_t   head_item,
	output logic                  pop,
	output logic                  m_tvalid,
	input  wire logic             m_tready,
	output logic [31:0]           m_tdata,
	output logic [2:0]            m_tuser,
	output logic                  m_tlast
);
	import sbc_pkg::*;

	typedef enum logic [2:0] {
		ST_LOAD  = 3'b001,
		ST_ROUND = 3'b010,
		ST_DONE  = 3'b100
	} state_t;

	state_t             state_q;
	logic [RND_W-1:0]   rnd_q;
	logic [WORD_W-1:0]  cv_q   [DIG_N];
	logic [WORD_W-1:0]  v_q    [DIG_N];
	logic [WORD_W-1:0]  w_q    [SCHED_N];
	logic [WORD_W-1:0]  dig_q  [DIG_N];
	logic [IDX_W-1:0]   idx_q;
	logic               act_q;

	logic [WORD_W-1:0]  w_new;
	logic [WORD_W-1:0]  t1;
	logic [WORD_W-1:0]  t2;
	logic               out_go;
	logic               fin_go;

	assign pop    = (state_q == ST_LOAD) && q_stat.valid;
	assign out_go = act_q && m_tready;
	assign fin_go = (state_q == ST_DONE) && !act_q;

	// W[t+16] from the window W[t..t+15]
	assign w_new = w_q[0] + sml_sig0(w_q[1]) + w_q[9] + sml_sig1(w_q[14]);

	assign t1 = v_q[7] + big_sig1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
	          + K_TABLE[rnd_q] + w_q[0];
	assign t2 = big_sig0(v_q[0])
	          + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));

	assign m_tvalid = act_q;
	assign m_tdata  = dig_q[0];
	assign m_tuser  = idx_q;
	assign m_tlast  = (idx_q == IDX_LAST);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			rnd_q   <= '0;
			act_q   <= 1'b0;
			idx_q   <= '0;
			for (int j = 0; j < DIG_N; j++) begin
				cv_q[j] <= IV_TABLE[j];
			end
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (pop) begin
						if (head_item.reload) begin
							for (int j = 0; j < DIG_N; j++) begin
								cv_q[j] <= IV_TABLE[j];
							end
						end
						if (head_item.blk_end) begin
							rnd_q   <= '0;
							state_q <= ST_ROUND;
						end
					end
				end
				ST_ROUND: begin
					rnd_q <= rnd_q + 1'b1;
					if (rnd_q == RND_LAST) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (fin_go) begin
						for (int j = 0; j < DIG_N; j++) begin
							cv_q[j] <= cv_q[j] + v_q[j];
						end
						state_q <= ST_LOAD;
					end
				end
				default: state_q <= ST_LOAD;
			endcase

			if (fin_go) begin
				act_q <= 1'b1;
				idx_q <= '0;
			end else if (out_go) begin
				idx_q <= idx_q + 1'b1;
				if (idx_q == IDX_LAST) begin
					act_q <= 1'b0;
				end
			end
		end
	end

	// payload: schedule window, working variables, digest buffer
	always_ff @(posedge clk) begin
		if (pop) begin
			for (int j = 0; j < SCHED_N - 1; j++) begin
				w_q[j] <= w_q[j+1];
			end
			w_q[SCHED_N-1] <= head_item.word;
			if (head_item.blk_end) begin
				for (int j = 0; j < DIG_N; j++) begin
					v_q[j] <= head_item.reload ? IV_TABLE[j] : cv_q[j];
				end
			end
		end else if (state_q == ST_ROUND) begin
			for (int j = 0; j < SCHED_N - 1; j++) begin
				w_q[j] <= w_q[j+1];
			end
			w_q[SCHED_N-1] <= w_new;
			v_q[0] <= t1 + t2;
			v_q[1] <= v_q[0];
			v_q[2] <= v_q[1];
			v_q[3] <= v_q[2];
			v_q[4] <= v_q[3] + t1;
			v_q[5] <= v_q[4];
			v_q[6] <= v_q[5];
			v_q[7] <= v_q[6];
		end

		if (fin_go) begin
			for (int j = 0; j < DIG_N; j++) begin
				dig_q[j] <= cv_q[j] + v_q[j];
			end
		end else if (out_go) begin
			for (int j = 0; j < DIG_N - 1; j++) begin
				dig_q[j] <= dig_q[j+1];
			end
			dig_q[DIG_N-1] <= dig_q[DIG_N-1];
		end
	end

endmodule
`default_nettype wire

### rtl/sha256_block_compress.sv
`timescale 1ns / 1ps
`default_nettype none
// SHA-256 compression engine. Send the padded message as 32-bit big-endian
// words on s_*, sixteen per 512-bit block; set s_tuser on a word to reload
// the standard initial hash values before that word is taken (normally on
// the first word of a message). Each completed block returns the eight
// updated chaining words on m_*, index 0 (most significant) first, with
// m_tuser carrying the index and m_tlast on index 7. A front stage counts
// word positions and feeds a four-entry request queue; the back end pops
// one word a cycle, while it is loading and the queue holds words, into a
// 16-word shifting schedule window, then runs one round per cycle. Each
// block takes its 16 pops, then 64 rounds, then a final add; the round
// datapath is the limit. The digest sits in its own output buffer, so the
// next block loads while the previous digest drains; only a stall that keeps
// that digest draining past the next block's rounds holds the final add.
module sha256_block_compress (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,   // [31:0] message_word
	input  wire logic [0:0]  s_tuser,   // [0] new_message
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,   // [31:0] digest_word
	output logic [2:0]       m_tuser,   // [2:0] digest_index
	output logic             m_tlast    // last_word
);
	import sbc_pkg::*;

	q_stat_t q_stat;
	item_t   push_item;
	item_t   head_item;
	logic    push;
	logic    pop;

	sbc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.q_stat    (q_stat),
		.push      (push),
		.push_item (push_item)
	);

	sbc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head_item (head_item),
		.q_stat    (q_stat)
	);

	sbc_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_stat    (q_stat),
		.head_item (head_item),
		.pop       (pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule
`default_nettype wire

### rtl/sbc_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module sbc_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic [31:0] s_tdata,
	input wire logic [0:0]  s_tuser,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [31:0] m_tdata,
	input wire logic [2:0]  m_tuser,
	input wire logic        m_tlast
);

	// stalled digest word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("digest word changed under stall");

	// tlast marks index 7 only
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tlast == (m_tuser == 3'd7)))
		else $error("tlast does not match index 7");

	// a digest run streams its indexes in order without a gap
	a_step: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=>
			m_tvalid && (m_tuser == $past(m_tuser) + 3'd1))
		else $error("digest index out of order");

	// a run starts at index 0
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> (m_tuser == 3'd0))
		else $error("digest run not starting at index 0");

endmodule

bind sha256_block_compress sbc_checker u_sbc_checker (.*);
`default_nettype wire

### tb/sv/sha256_block_compress_tb.sv
`timescale 1ns / 1ps
module sha256_block_compress_tb;
	import sbc_pkg::*;

	localparam int WATCHDOG_CYCLES = 20000;
	localparam int LONG_STALL      = 1500;
	localparam int TAIL_CYCLES     = 200;
	localparam int RANDOM_BLOCKS   = 31;

	localparam logic [31:0] H_INIT [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] RC [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	// one message word to send, or a pause until all digests are back
	typedef struct {
		logic [31:0] word;
		logic        fresh;
		bit          drain;
	} feed_t;

	typedef struct {
		logic [31:0]      word;
		logic [IDX_W-1:0] idx;
		logic             last;
	} digest_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata  = '0;
	logic [0:0]  s_tuser  = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic [2:0]  m_tuser;
	logic        m_tlast;

	feed_t   word_feed [$];
	digest_t digest_q [$];

	// predictor state
	logic [31:0]      chain [8];
	logic [31:0]      sched [16];
	logic [POS_W-1:0] wpos;

	int words_in     = 0;
	int digests_out  = 0;
	int reloads      = 0;
	int err_count    = 0;
	int send_gap     = 0;
	int ready_gap    = 0;
	int idle_cycles  = 0;
	bit stall_done   = 1'b0;

	sha256_block_compress uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),   // [31:0] message_word
		.s_tuser  (s_tuser),   // [0] new_message
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),   // [31:0] digest_word
		.m_tuser  (m_tuser),   // [2:0] digest_index
		.m_tlast  (m_tlast)    // last_word
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [31:0] ror(logic [31:0] x, int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	// take one word into the model; a block's sixteenth word runs the 64 rounds
	// and queues the eight chaining words
	function automatic void absorb_word(logic [31:0] w, logic fresh);
		logic [31:0] ws [16];
		logic [31:0] v [8];
		logic [31:0] wi, t1, t2, x1, x14;
		digest_t     d;
		if (fresh)
			chain = H_INIT;
		sched[wpos] = w;
		if (wpos != POS_LAST) begin
			wpos = wpos + 1'b1;
			return;
		end
		wpos = '0;
		ws = sched;
		v = chain;
		for (int r = 0; r < 64; r++) begin
			if (r < 16) begin
				wi = ws[r];
			end else begin
				x1  = ws[(r + 1) % 16];
				x14 = ws[(r + 14) % 16];
				wi = ws[r % 16] + (ror(x1, 7) ^ ror(x1, 18) ^ (x1 >> 3))
				   + (ror(x14, 17) ^ ror(x14, 19) ^ (x14 >> 10)) + ws[(r + 9) % 16];
				ws[r % 16] = wi;
			end
			t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
			   + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RC[r] + wi;
			t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
			   + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			for (int j = 7; j > 0; j--)
				v[j] = v[j - 1];
			v[4] = v[4] + t1;
			v[0] = t1 + t2;
		end
		for (int j = 0; j < DIG_N; j++) begin
			chain[j] = chain[j] + v[j];
			d.word = chain[j];
			d.idx  = j[IDX_W-1:0];
			d.last = (d.idx == IDX_LAST);
			digest_q.push_back(d);
		end
	endfunction

	// mostly back-to-back, sometimes a short gap, rarely a long gap; none when calm
	function automatic int pick_gap(bit calm);
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 9))
			0: return 32'h0000_0000;
			1: return 32'hffff_ffff;
			2: return 32'h1 << $urandom_range(0, 31);
			default: return $urandom;
		endcase
	endfunction

	function automatic void add_word(logic [31:0] w, logic fresh);
		feed_t f;
		f.word  = w;
		f.fresh = fresh;
		f.drain = 1'b0;
		word_feed.push_back(f);
	endfunction

	function automatic void add_drain();
		feed_t f;
		f.word  = '0;
		f.fresh = 1'b0;
		f.drain = 1'b1;
		word_feed.push_back(f);
	endfunction

	// driver: holds an offer until taken, then waits out its gap
	always @(posedge clk) begin
		feed_t f;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				absorb_word(s_tdata, s_tuser[0]);
				words_in++;
				if (s_tuser[0])
					reloads++;
			end
			if (!(s_tvalid && !s_tready)) begin
				if (send_gap > 0) begin
					send_gap--;
					s_tvalid <= 1'b0;
				end else if (word_feed.size() == 0) begin
					s_tvalid <= 1'b0;
				end else if (word_feed[0].drain) begin
					// sender pause: resume only once every digest is back
					s_tvalid <= 1'b0;
					if (digest_q.size() == 0)
						void'(word_feed.pop_front());
				end else begin
					f = word_feed.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= f.word;
					s_tuser  <= f.fresh;
					send_gap = pick_gap((words_in % 64) < 16);
				end
			end
		end
	end

	// monitor: checks each digest word against the oldest prediction
	always @(posedge clk) begin
		digest_t d;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				digests_out++;
				if (digest_q.size() == 0) begin
					err_count++;
					$display("%0t: unexpected digest word %h idx %0d last %b",
						$time, m_tdata, m_tuser, m_tlast);
				end else begin
					d = digest_q.pop_front();
					if (m_tdata !== d.word || m_tuser !== d.idx || m_tlast !== d.last) begin
						err_count++;
						$display("%0t: digest mismatch exp %h/%0d/%b got %h/%0d/%b",
							$time, d.word, d.idx, d.last, m_tdata, m_tuser, m_tlast);
					end
				end
				ready_gap = pick_gap((digests_out % 48) < 16);
				// one long hold-off so the input queue fills and backs up
				if (digests_out == 40 && !stall_done) begin
					stall_done = 1'b1;
					ready_gap = LONG_STALL;
				end
			end
			if (ready_gap > 0) begin
				ready_gap--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// watchdog: too long with nothing moving on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= WATCHDOG_CYCLES) begin
				$display("watchdog expired at %0t", $time);
				$display("end of test: mismatches");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin
		int  nblk;
		int  blocks;
		bit  drained;
		chain = H_INIT;
		wpos = '0;
		for (int i = 0; i < 16; i++)
			sched[i] = '0;

		// directed block: reload on word 0, extreme words, a second reload
		// mid-block (word 9), last word all ones
		add_word(32'h6162_6380, 1'b1);
		for (int i = 1; i < 15; i++)
			add_word((i % 2) ? 32'hffff_ffff : 32'h0000_0000, i == 9);
		add_word(32'hffff_ffff, 1'b0);
		add_drain();

		// random messages of one to four blocks; most start with a reload,
		// some continue the previous chain, a few reload on a later word
		blocks = 0;
		drained = 1'b0;
		while (blocks < RANDOM_BLOCKS) begin
			nblk = $urandom_range(1, 4);
			for (int b = 0; b < nblk; b++) begin
				if (blocks >= 16 && !drained) begin
					add_drain();
					drained = 1'b1;
				end
				for (int i = 0; i < 16; i++)
					add_word(rand_word(),
						(i == 0 && b == 0) ? ($urandom_range(0, 7) != 0)
						                   : ($urandom_range(0, 19) == 0));
				blocks++;
			end
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		while (word_feed.size() != 0 || s_tvalid || digest_q.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("sent %0d message words (%0d with reload), checked %0d digest words",
			words_in, reloads, digests_out);
		$display("with random gaps on both sides, one long output stall and drain pauses");
		if (err_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
